@@ rtl/ucer_pkg.sv @@
// ============================================================================
// ucer_pkg: shared types, codes and descriptor tables for the USB control
// endpoint responder.
// Holds request codes, result kinds, sequencer step codes, the microcode
// table and the descriptor ROM.
// ============================================================================
package ucer_pkg;

   // Event codes on the request side
   typedef enum logic [1:0] {
      CMD_BUS_RESET = 2'd0,
      CMD_SETUP     = 2'd1,
      CMD_IN_DONE   = 2'd2,
      CMD_NONE      = 2'd3
   } cmd_type;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_DATA    = 3'd0,
      KIND_ZLP     = 3'd1,
      KIND_OUT_ARM = 3'd2,
      KIND_STALL   = 3'd3,
      KIND_ADDRESS = 3'd4
   } kind_type;

   // Setup request codes
   localparam logic [7:0] RT_DEV_IN      = 8'h80;
   localparam logic [7:0] RT_DEV_OUT     = 8'h00;
   localparam logic [7:0] RT_CLASS_IF    = 8'h21;
   localparam logic [7:0] RQ_GET_STATUS  = 8'h00;
   localparam logic [7:0] RQ_SET_ADDRESS = 8'h05;
   localparam logic [7:0] RQ_GET_DESC    = 8'h06;
   localparam logic [7:0] RQ_SET_CONFIG  = 8'h09;
   localparam logic [7:0] RQ_SET_LINE    = 8'h20;
   localparam logic [7:0] RQ_SET_CTRL    = 8'h22;

   // Descriptor types
   localparam logic [7:0] DT_DEVICE    = 8'h01;
   localparam logic [7:0] DT_CONFIG    = 8'h02;
   localparam logic [7:0] DT_STRING    = 8'h03;
   localparam logic [7:0] DT_QUALIFIER = 8'h06;

   // ROM sources
   localparam logic [2:0] SRC_DEVICE    = 3'd0;
   localparam logic [2:0] SRC_QUALIFIER = 3'd1;
   localparam logic [2:0] SRC_CONFIG    = 3'd2;
   localparam logic [2:0] SRC_STRING0   = 3'd3;
   localparam logic [2:0] SRC_STATUS    = 3'd7;

   localparam int unsigned ROM_DEPTH = 153;
   localparam logic [6:0] MAX_SRC_LEN = 7'h4b;

   localparam logic [7:0] SRC_BASE [8] = '{
      8'd0, 8'd18, 8'd28, 8'd103, 8'd107, 8'd123, 8'd137, 8'd151
   };
   localparam logic [6:0] SRC_LEN [8] = '{
      7'h12, 7'h0a, 7'h4b, 7'd4, 7'd16, 7'd14, 7'd14, 7'd2
   };

   localparam logic [7:0] DESC_ROM [ROM_DEPTH] = '{
      // device
      8'h12, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h40, 8'hdb, 8'hdb,
      8'h78, 8'h56, 8'h00, 8'h01, 8'h01, 8'h02, 8'h03, 8'h01,
      // qualifier
      8'h0a, 8'h06, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h40, 8'h01, 8'h00,
      // configuration
      8'h09, 8'h02, 8'h4b, 8'h00, 8'h02, 8'h01, 8'h00, 8'h80, 8'hfa,
      8'h08, 8'h0b, 8'h00, 8'h02, 8'h02, 8'h02, 8'h00, 8'h00,
      8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02, 8'h00, 8'h00,
      8'h05, 8'h24, 8'h00, 8'h10, 8'h01,
      8'h04, 8'h24, 8'h02, 8'h02,
      8'h05, 8'h24, 8'h06, 8'h00, 8'h01,
      8'h05, 8'h24, 8'h01, 8'h03, 8'h01,
      8'h07, 8'h05, 8'h83, 8'h03, 8'h08, 8'h00, 8'hff,
      8'h09, 8'h04, 8'h01, 8'h00, 8'h02, 8'h0a, 8'h00, 8'h00, 8'h00,
      8'h07, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00,
      8'h07, 8'h05, 8'h02, 8'h02, 8'h40, 8'h00, 8'h00,
      // string 0
      8'h04, 8'h03, 8'h09, 8'h04,
      // string 1
      8'h10, 8'h03, 8'h54, 8'h00, 8'h65, 8'h00, 8'h73, 8'h00, 8'h74, 8'h00,
      8'h69, 8'h00, 8'h6e, 8'h00, 8'h67, 8'h00,
      // string 2
      8'h0e, 8'h03, 8'h50, 8'h00, 8'h69, 8'h00, 8'h63, 8'h00, 8'h6f, 8'h00,
      8'h32, 8'h00, 8'h57, 8'h00,
      // string 3
      8'h0e, 8'h03, 8'h31, 8'h00, 8'h32, 8'h00, 8'h33, 8'h00, 8'h34, 8'h00,
      8'h35, 8'h00, 8'h36, 8'h00,
      // status
      8'h00, 8'h00
   };

   // Sequencer steps (microcode addresses)
   typedef enum logic [3:0] {
      ST_IDLE     = 4'd0,
      ST_BUSRST   = 4'd1,
      ST_STALL    = 4'd2,
      ST_SETADDR  = 4'd3,
      ST_TAKE_ACK = 4'd4,
      ST_ZLP      = 4'd5,
      ST_START    = 4'd6,
      ST_PKT      = 4'd7,
      ST_BYTE     = 4'd8,
      ST_INDONE   = 4'd9,
      ST_INDONE2  = 4'd10,
      ST_NEWADDR  = 4'd11,
      ST_TAKE_OUT = 4'd12,
      ST_OUTARM   = 4'd13
   } step_type;

   // Datapath actions
   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_SETPEND = 3'd1,
      ACT_TAKE    = 3'd2,
      ACT_LOAD    = 3'd3,
      ACT_PKT     = 3'd4,
      ACT_BYTE    = 3'd5,
      ACT_APPLY   = 3'd6
   } act_type;

   // Jump conditions
   typedef enum logic [2:0] {
      CND_NONE      = 3'd0,
      CND_DISPATCH  = 3'd1,
      CND_REM_ZERO  = 3'd2,
      CND_BYTE_LAST = 3'd3,
      CND_PEND      = 3'd4,
      CND_REM_NZ    = 3'd5
   } cond_type;

   // One control word
   typedef struct packed {
      logic     emit;
      kind_type kind;
      logic     last;
      act_type  act;
      cond_type cond;
      step_type jump;
      step_type next;
   } uword_type;

   // Microcode ROM: jump is taken when cond holds, else next
   function automatic uword_type ucode(input step_type s);
      uword_type w;
      w.emit = 1'b0;
      w.kind = KIND_DATA;
      w.last = 1'b0;
      w.act  = ACT_NONE;
      w.cond = CND_NONE;
      w.jump = ST_IDLE;
      w.next = ST_IDLE;
      unique case (s)
         ST_IDLE: begin
            w.cond = CND_DISPATCH;
         end
         ST_BUSRST: begin
            w.emit = 1'b1; w.kind = KIND_ADDRESS; w.last = 1'b1;
         end
         ST_STALL: begin
            w.emit = 1'b1; w.kind = KIND_STALL; w.last = 1'b1;
         end
         ST_SETADDR: begin
            w.act = ACT_SETPEND; w.next = ST_TAKE_ACK;
         end
         ST_TAKE_ACK: begin
            w.act = ACT_TAKE; w.next = ST_ZLP;
         end
         ST_ZLP: begin
            w.emit = 1'b1; w.kind = KIND_ZLP; w.last = 1'b1;
         end
         ST_START: begin
            w.act = ACT_LOAD; w.next = ST_PKT;
         end
         ST_PKT: begin
            w.act = ACT_PKT; w.cond = CND_REM_ZERO;
            w.jump = ST_ZLP; w.next = ST_BYTE;
         end
         ST_BYTE: begin
            w.emit = 1'b1; w.kind = KIND_DATA; w.act = ACT_BYTE;
            w.cond = CND_BYTE_LAST; w.jump = ST_IDLE; w.next = ST_BYTE;
         end
         ST_INDONE: begin
            w.cond = CND_PEND; w.jump = ST_NEWADDR; w.next = ST_INDONE2;
         end
         ST_INDONE2: begin
            w.cond = CND_REM_NZ; w.jump = ST_PKT; w.next = ST_TAKE_OUT;
         end
         ST_NEWADDR: begin
            w.emit = 1'b1; w.kind = KIND_ADDRESS; w.last = 1'b1;
            w.act = ACT_APPLY;
         end
         ST_TAKE_OUT: begin
            w.act = ACT_TAKE; w.next = ST_OUTARM;
         end
         ST_OUTARM: begin
            w.emit = 1'b1; w.kind = KIND_OUT_ARM; w.last = 1'b1;
         end
         default: begin
            w.next = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

@@ rtl/usb_control_endpoint_responder.sv @@
// ============================================================================
// usb_control_endpoint_responder: endpoint-zero responder for a full-speed
// CDC serial device.
// Decodes bus-reset, setup and IN-done events with a small microcoded
// sequencer and emits packet bytes, acknowledgements, stalls, OUT arms and address
// updates.
// ============================================================================
// Usage:
//   req_* carries one event word: tuser is the event code, tdata the setup
//   fields. rsp_* returns the result words of that event, one per cycle at
//   best, with tlast on the final word of the event.
//   A step of the control program that emits a word waits until the output
//   register is free. The byte loop of the sequencer, one descriptor ROM
//   read per cycle while the output register is free, sets the throughput.
//   A new event is taken only when the sequencer is back at its idle step;
//   the last result word may still sit in the output register then.
//   Reset clears the toggle, pending address, transfer pointers and the
//   output register; no clearing pass is needed.
//   When the receiver holds rsp_tready low, the current word holds in the
//   output register and the sequencer waits on its emitting step.
// ============================================================================
module usb_control_endpoint_responder #(
   parameter int unsigned MAX_PACKET = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Event input
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] request_type, [15:8] request, [31:16] request_value,
   // [47:32] request_length
   input  logic [47:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]  req_tuser,
   // Result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] data_byte, [14:8] packet_length, [15] data_pid,
   // [16] final_packet, [23:17] device_address
   output logic [23:0] rsp_tdata,
   // [2:0] kind
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam logic [6:0] MaxPkt = 7'(MAX_PACKET);

   // Sequencer and transfer state
   ucer_pkg::step_type step_ff, step_in;
   ucer_pkg::step_type entry;
   logic       toggle_ff, toggle_in;
   logic [6:0] pend_ff, pend_in;
   logic [2:0] sel_ff, sel_in;
   logic [6:0] off_ff, off_in;
   logic [6:0] rem_ff, rem_in;
   logic       pid_ff, pid_in;
   logic       fin_ff, fin_in;
   logic [6:0] plen_ff, plen_in;
   logic [6:0] idx_ff, idx_in;

   // Latched setup fields
   logic [2:0]  dsel_ff, dsel_in;
   logic [6:0]  val_ff, val_in;
   logic [15:0] wlen_ff, wlen_in;

   // Output register
   logic        ovalid_ff, ovalid_in;
   logic [23:0] odata_ff, odata_in;
   logic [2:0]  okind_ff, okind_in;
   logic        olast_ff, olast_in;

   ucer_pkg::uword_type uw;
   ucer_pkg::cmd_type   cmd;
   logic [2:0] dsel;
   logic [7:0] rtype, rqst, dtype, didx;
   logic       accept, out_free, go, cond_true, byte_last;
   logic [7:0] rom_off, rom_addr, rom_byte;
   logic       rom_valid;
   logic [6:0] pkt_n;
   logic [7:0] o_byte;
   logic [6:0] o_len, o_addr;
   logic       o_pid, o_fin;

   assign uw    = ucer_pkg::ucode(step_ff);
   assign cmd   = ucer_pkg::cmd_type'(req_tuser);
   assign rtype = req_tdata[7:0];
   assign rqst  = req_tdata[15:8];
   assign didx  = req_tdata[23:16];
   assign dtype = req_tdata[31:24];

   assign req_tready = (step_ff == ucer_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !ovalid_ff || rsp_tready;
   assign go         = !uw.emit || out_free;

   // Decode an event into its entry step and ROM source
   always_comb begin
      entry = ucer_pkg::ST_STALL;
      dsel  = ucer_pkg::SRC_DEVICE;
      unique case (cmd)
         ucer_pkg::CMD_BUS_RESET: entry = ucer_pkg::ST_BUSRST;
         ucer_pkg::CMD_IN_DONE:   entry = ucer_pkg::ST_INDONE;
         ucer_pkg::CMD_NONE:      entry = ucer_pkg::ST_IDLE;
         ucer_pkg::CMD_SETUP: begin
            if (rtype == ucer_pkg::RT_DEV_IN) begin
               if (rqst == ucer_pkg::RQ_GET_DESC) begin
                  entry = ucer_pkg::ST_START;
                  if (dtype == ucer_pkg::DT_DEVICE) begin
                     dsel = ucer_pkg::SRC_DEVICE;
                  end else if (dtype == ucer_pkg::DT_QUALIFIER) begin
                     dsel = ucer_pkg::SRC_QUALIFIER;
                  end else if (dtype == ucer_pkg::DT_CONFIG) begin
                     dsel = ucer_pkg::SRC_CONFIG;
                  end else if (dtype == ucer_pkg::DT_STRING) begin
                     // string indices above three fall back to string zero
                     dsel = (didx > 8'd3) ? ucer_pkg::SRC_STRING0
                                          : ucer_pkg::SRC_STRING0 + didx[2:0];
                  end else begin
                     entry = ucer_pkg::ST_STALL;
                  end
               end else if (rqst == ucer_pkg::RQ_GET_STATUS) begin
                  entry = ucer_pkg::ST_START;
                  dsel  = ucer_pkg::SRC_STATUS;
               end
            end else if (rtype == ucer_pkg::RT_DEV_OUT) begin
               if (rqst == ucer_pkg::RQ_SET_ADDRESS) begin
                  entry = ucer_pkg::ST_SETADDR;
               end else if (rqst == ucer_pkg::RQ_SET_CONFIG) begin
                  entry = ucer_pkg::ST_TAKE_ACK;
               end
            end else if (rtype == ucer_pkg::RT_CLASS_IF) begin
               if (rqst == ucer_pkg::RQ_SET_LINE || rqst == ucer_pkg::RQ_SET_CTRL) begin
                  entry = ucer_pkg::ST_TAKE_ACK;
               end
            end
         end
         default: entry = ucer_pkg::ST_IDLE;
      endcase
   end

   // Descriptor ROM read, clipped to the source length
   assign rom_off   = {1'b0, off_ff} + {1'b0, idx_ff};
   assign rom_valid = rom_off < {1'b0, ucer_pkg::SRC_LEN[sel_ff]};
   assign rom_addr  = rom_valid ? (ucer_pkg::SRC_BASE[sel_ff] + rom_off) : 8'd0;
   assign rom_byte  = rom_valid ? ucer_pkg::DESC_ROM[rom_addr] : 8'd0;

   assign pkt_n     = (rem_ff > MaxPkt) ? MaxPkt : rem_ff;
   assign byte_last = (idx_ff == plen_ff - 7'd1);

   // Evaluate the jump condition of the current control word
   always_comb begin
      case (uw.cond)
         ucer_pkg::CND_DISPATCH:  cond_true = accept;
         ucer_pkg::CND_REM_ZERO:  cond_true = (rem_ff == 7'd0);
         ucer_pkg::CND_BYTE_LAST: cond_true = byte_last;
         ucer_pkg::CND_PEND:      cond_true = (pend_ff != 7'd0);
         ucer_pkg::CND_REM_NZ:    cond_true = (rem_ff != 7'd0);
         default:                 cond_true = 1'b0;
      endcase
   end

   // Build the result fields for the emitting step
   always_comb begin
      o_byte = 8'd0;
      o_len  = 7'd0;
      o_pid  = 1'b0;
      o_fin  = 1'b0;
      o_addr = 7'd0;
      case (uw.kind)
         ucer_pkg::KIND_DATA: begin
            o_byte = rom_byte;
            o_len  = plen_ff;
            o_pid  = pid_ff;
            o_fin  = fin_ff;
         end
         ucer_pkg::KIND_ZLP: begin
            o_pid = pid_ff;
            o_fin = 1'b1;
         end
         ucer_pkg::KIND_OUT_ARM: o_pid = pid_ff;
         ucer_pkg::KIND_ADDRESS: o_addr = pend_ff;
         default: ;
      endcase
   end

   // Next-state logic: datapath actions and step sequencing
   always_comb begin
      step_in   = step_ff;
      toggle_in = toggle_ff;
      pend_in   = pend_ff;
      sel_in    = sel_ff;
      off_in    = off_ff;
      rem_in    = rem_ff;
      pid_in    = pid_ff;
      fin_in    = fin_ff;
      plen_in   = plen_ff;
      idx_in    = idx_ff;
      dsel_in   = dsel_ff;
      val_in    = val_ff;
      wlen_in   = wlen_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in  = odata_ff;
      okind_in  = okind_ff;
      olast_in  = olast_ff;

      // take an event: latch fields and apply its immediate clears
      if (accept) begin
         dsel_in = dsel;
         val_in  = req_tdata[22:16];
         wlen_in = req_tdata[47:32];
         if (cmd == ucer_pkg::CMD_BUS_RESET) begin
            toggle_in = 1'b0;
            pend_in   = 7'd0;
            sel_in    = ucer_pkg::SRC_DEVICE;
            off_in    = 7'd0;
            rem_in    = 7'd0;
         end else if (cmd == ucer_pkg::CMD_SETUP) begin
            toggle_in = 1'b1;
            off_in    = 7'd0;
            rem_in    = 7'd0;
         end
      end

      if (go) begin
         step_in = cond_true ? uw.jump : uw.next;
         if (uw.cond == ucer_pkg::CND_DISPATCH) begin
            step_in = accept ? entry : ucer_pkg::ST_IDLE;
         end

         unique case (uw.act)
            ucer_pkg::ACT_SETPEND: pend_in = val_ff;
            ucer_pkg::ACT_TAKE: begin
               pid_in    = toggle_ff;
               toggle_in = !toggle_ff;
            end
            ucer_pkg::ACT_LOAD: begin
               sel_in = dsel_ff;
               off_in = 7'd0;
               rem_in = (wlen_ff < {9'd0, ucer_pkg::SRC_LEN[dsel_ff]})
                        ? wlen_ff[6:0] : ucer_pkg::SRC_LEN[dsel_ff];
            end
            ucer_pkg::ACT_PKT: begin
               pid_in    = toggle_ff;
               toggle_in = !toggle_ff;
               plen_in   = pkt_n;
               fin_in    = (rem_ff <= MaxPkt);
               idx_in    = 7'd0;
            end
            ucer_pkg::ACT_BYTE: begin
               idx_in = idx_ff + 7'd1;
               if (byte_last) begin
                  off_in = off_ff + plen_ff;
                  rem_in = rem_ff - plen_ff;
               end
            end
            ucer_pkg::ACT_APPLY: pend_in = 7'd0;
            default: ;
         endcase

         // load the output register
         if (uw.emit) begin
            ovalid_in = 1'b1;
            odata_in  = {o_addr, o_fin, o_pid, o_len, o_byte};
            okind_in  = uw.kind;
            olast_in  = uw.last || (uw.kind == ucer_pkg::KIND_DATA && byte_last);
         end
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= ucer_pkg::ST_IDLE;
         toggle_ff <= 1'b0;
         pend_ff   <= 7'd0;
         sel_ff    <= 3'd0;
         off_ff    <= 7'd0;
         rem_ff    <= 7'd0;
         ovalid_ff <= 1'b0;
      end else begin
         step_ff   <= step_in;
         toggle_ff <= toggle_in;
         pend_ff   <= pend_in;
         sel_ff    <= sel_in;
         off_ff    <= off_in;
         rem_ff    <= rem_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pid_ff   <= pid_in;
      fin_ff   <= fin_in;
      plen_ff  <= plen_in;
      idx_ff   <= idx_in;
      dsel_ff  <= dsel_in;
      val_ff   <= val_in;
      wlen_ff  <= wlen_in;
      odata_ff <= odata_in;
      okind_ff <= okind_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;

   // Byte loop stays inside the packet
   a_idx_in_packet: assert property (@(posedge clock) disable iff (reset)
      step_ff == ucer_pkg::ST_BYTE |-> (idx_ff < plen_ff && plen_ff <= MaxPkt))
      else $error("byte index outside packet");

   // Remaining count never exceeds the longest descriptor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= ucer_pkg::MAX_SRC_LEN)
      else $error("remaining count out of range");

   // A zero-length packet always ends the transfer with no bytes
   a_zlp_final: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff && okind_ff == ucer_pkg::KIND_ZLP
         |-> (odata_ff[16] && odata_ff[14:8] == 7'd0 && olast_ff))
      else $error("malformed zero-length packet");

   // A word is loaded only into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff && !rsp_tready |=> ovalid_ff && $stable(odata_ff))
      else $error("output word overwritten while stalled");

endmodule
